@@ design/sai_cache_pkg.sv @@
// Shared types and constants for the set-associative instruction cache.
package sai_cache_pkg;
    localparam int SETS       = 64;
    localparam int WAYS       = 4;
    localparam int LINE_BYTES = 64;
    localparam int BEATS      = LINE_BYTES / 8;
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int SET_W      = $clog2(SETS);
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BEAT_W     = $clog2(BEATS);
    localparam int TAG_W      = 32 - OFF_W - SET_W;
    localparam int ENTRIES    = SETS * WAYS;
    localparam int WORDS      = ENTRIES * BEATS;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int ENT_W      = $clog2(ENTRIES);
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic ACT_FETCH  = 1'b0;
    localparam logic ACT_REFILL = 1'b1;
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REQ   = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] fetch_address;
        logic [3:0]  fetch_length;
        logic [63:0] refill_data;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] read_data;
        logic [31:0] refill_address;
        logic [1:0]  refill_way;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TAG, ST_LOOK, ST_RD0, ST_RD1, ST_MERGE, ST_WAIT_BEAT, ST_EMIT
    } bk_state_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        lfsr_step = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction
endpackage

@@ design/sai_front.sv @@
// Front part: queues items as-is, clamping fetch lengths over eight.
module sai_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sai_cache_pkg::in_item_t in_item,
    output logic                    q_valid,
    input  logic                    q_ready,
    output sai_cache_pkg::in_item_t q_item
);
    import sai_cache_pkg::*;

    // two-entry queue
    in_item_t  buf_reg [2];
    in_item_t  in_fix;
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // clamp length above eight
    always_comb
    begin
        in_fix = in_item;
        if (in_item.fetch_length > 4'd8)
            in_fix.fetch_length = 4'd8;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= in_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2) else $error("queue lost item");
endmodule

@@ design/sai_back.sv @@
// Back part: tag lookup, allocation, refill and data read sequencer.
module sai_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  sai_cache_pkg::in_item_t  q_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sai_cache_pkg::out_item_t out_item
);
    import sai_cache_pkg::*;

    bk_state_t state_reg, state_next;
    logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
    logic [63:0]      data_mem [WORDS];
    logic [ENTRIES-1:0] valid_reg;
    logic [15:0] lfsr_reg;
    logic [31:0] addr_reg;      // pending address
    logic [3:0]  len_reg;
    logic        part_reg;      // 0 first, 1 second
    logic [1:0]  pend_reg;      // 0 idle / 1,2 refilling
    logic [63:0] part_res_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [WAY_W-1:0]  way_reg;
    out_item_t   out_reg;
    logic        out_v_reg;

    // per-part geometry
    logic [OFF_W:0] off1, first_len;
    logic [3:0]  cur_len;
    logic [31:0] cur_addr;
    logic [OFF_W-1:0] cur_off;
    logic [SET_W-1:0] cur_set;
    logic [TAG_W-1:0] cur_tag;

    assign off1 = {1'b0, addr_reg[OFF_W-1:0]};
    always_comb
    begin
        if (off1 + {{(OFF_W-3){1'b0}}, len_reg} > (OFF_W+1)'(LINE_BYTES))
            first_len = (OFF_W+1)'(LINE_BYTES) - off1;
        else
            first_len = {{(OFF_W-3){1'b0}}, len_reg};
    end
    assign cur_addr = part_reg ? addr_reg + 32'(first_len) : addr_reg;
    assign cur_len  = part_reg ? len_reg - 4'(first_len) : 4'(first_len);
    assign cur_off  = cur_addr[OFF_W-1:0];
    assign cur_set  = cur_addr[OFF_W +: SET_W];
    assign cur_tag  = cur_addr[31 -: TAG_W];

    // one set's tags, registered in ST_TAG and compared in ST_LOOK
    logic [WAYS-1:0][TAG_W-1:0] tags_q;
    logic [WAYS-1:0]  vld_q;
    logic [WAYS-1:0]  hit_vec;
    logic             hit;
    logic [WAY_W-1:0] hit_way, free_way, vict_way;
    logic             has_free;
    logic [15:0]      lfsr_adv;

    always_comb
    begin
        hit = 1'b0; hit_way = '0; has_free = 1'b0; free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            hit_vec[w] = vld_q[w] && tags_q[w] == cur_tag;
            if (hit_vec[w]) begin hit = 1'b1; hit_way = WAY_W'(w); end
            if (!vld_q[w]) begin has_free = 1'b1; free_way = WAY_W'(w); end
        end
    end
    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign vict_way = has_free ? free_way : WAY_W'(lfsr_adv % WAYS);

    // data read: two words span any <=8 byte window
    logic [WORD_AW-1:0] rd_addr, wr_addr;
    logic [63:0] rd_q, w0_reg;
    logic [BEAT_W-1:0] beat_sel;
    logic do_wr;
    assign beat_sel = cur_off[OFF_W-1:3] + ((state_reg == ST_RD1) ? BEAT_W'(1) : BEAT_W'(0));
    assign rd_addr  = {cur_set, way_reg, beat_sel};
    assign wr_addr  = {cur_set, way_reg, beat_reg};

    always_ff @(posedge clk)
    begin
        if (do_wr) data_mem[wr_addr] <= q_item.refill_data;
        rd_q   <= data_mem[rd_addr];
        tags_q <= tag_mem[cur_set];
        if (state_reg == ST_LOOK && !hit)
            tag_mem[cur_set][vict_way] <= cur_tag;
    end
    always_comb
        for (int w = 0; w < WAYS; w++)
            vld_q[w] = valid_reg[{cur_set, WAY_W'(w)}];

    // window extract from two words
    logic [127:0] pair;
    logic [63:0]  mask, d_part;
    assign pair   = {rd_q, w0_reg} >> {cur_off[2:0], 3'b000};
    assign mask   = (cur_len >= 4'd8) ? '1 : ((64'd1 << {cur_len, 3'b000}) - 64'd1);
    assign d_part = pair[63:0] & mask;

    logic q_take;
    always_comb
    begin
        state_next = state_reg;
        q_ready = 1'b0;
        do_wr = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !out_v_reg)
                begin
                    q_ready = 1'b1;
                    if (q_item.action == ACT_FETCH && q_item.fetch_length != 4'd0)
                        state_next = ST_TAG;
                end
            end
            ST_TAG:  state_next = ST_LOOK;
            ST_LOOK: state_next = hit ? ST_RD0 : ST_WAIT_BEAT;
            ST_WAIT_BEAT:
            begin
                if (q_valid && !out_v_reg)
                begin
                    q_ready = 1'b1;
                    if (q_item.action == ACT_REFILL)
                    begin
                        do_wr = 1'b1;
                        if (beat_reg == BEAT_W'(BEATS - 1)) state_next = ST_RD0;
                    end
                end
            end
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_MERGE;
            ST_MERGE:
            begin
                if (!part_reg && 4'(first_len) != len_reg)
                    state_next = ST_TAG;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_v_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
    assign q_take = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0; lfsr_reg <= 16'd1;
            pend_reg <= 2'd0; beat_reg <= '0; out_v_reg <= 1'b0;
            part_reg <= 1'b0; way_reg <= '0; addr_reg <= '0; len_reg <= '0;
            part_res_reg <= '0; w0_reg <= '0; out_reg <= '0;
        end
        else
        begin
            if (out_v_reg && out_ready) out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (q_take && q_item.action == ACT_FETCH)
                    begin
                        if (q_item.fetch_length == 4'd0)
                        begin
                            out_reg <= '{KIND_DATA, 64'd0, 32'd0, 2'd0};
                            out_v_reg <= 1'b1;
                        end
                        else
                        begin
                            addr_reg <= q_item.fetch_address;
                            len_reg <= q_item.fetch_length;
                            part_reg <= 1'b0;
                        end
                    end
                ST_LOOK:
                begin
                    if (hit)
                        way_reg <= hit_way;
                    else
                    begin
                        if (!has_free) lfsr_reg <= lfsr_adv;
                        valid_reg[{cur_set, vict_way}] <= 1'b1;
                        way_reg <= vict_way;
                        beat_reg <= '0;
                        pend_reg <= part_reg ? 2'd2 : 2'd1;
                        out_reg <= '{KIND_REQ, 64'd0,
                            {cur_addr[31:OFF_W], {OFF_W{1'b0}}}, 2'(vict_way)};
                        out_v_reg <= 1'b1;
                    end
                end
                ST_WAIT_BEAT:
                    if (q_take && q_item.action == ACT_REFILL)
                    begin
                        beat_reg <= beat_reg + BEAT_W'(1);
                        if (beat_reg == BEAT_W'(BEATS - 1)) pend_reg <= 2'd0;
                    end
                ST_RD1: w0_reg <= rd_q;
                ST_MERGE:
                begin
                    if (!part_reg)
                    begin
                        part_res_reg <= d_part;
                        if (4'(first_len) != len_reg) part_reg <= 1'b1;
                    end
                    else
                        part_res_reg <= part_res_reg | (d_part << {first_len, 3'b000});
                end
                ST_EMIT:
                    if (!out_v_reg)
                    begin
                        out_reg <= '{KIND_DATA, part_res_reg, 32'd0, 2'd0};
                        out_v_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT_BEAT) |-> pend_reg != 2'd0) else $error("wait without refill");
    assert property (@(posedge clk) disable iff (!rst_n)
        do_wr |-> state_reg == ST_WAIT_BEAT) else $error("stray line write");
    assert property (@(posedge clk) disable iff (!rst_n) lfsr_reg != 16'd0)
        else $error("lfsr locked at zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> !out_v_reg) else $error("lookup with result held");
endmodule

@@ design/set_assoc_instruction_cache.sv @@
// Top level of the 4-way set-associative instruction cache.
// Usage:
//  - in channel (in_valid/in_ready/in_item): fetch requests (action 0) and
//    refill beats (action 1) share one item stream.
//  - out channel (out_valid/out_ready/out_item): fetch data or a refill request.
//  - A front queue of two items takes items while the back sequencer works.
//  - Hit: the item passes the queue, then the back part's tag read, lookup,
//    two data-RAM reads, merge and emit; a fetch that crosses a line adds
//    a second tag read, lookup and reads.
//  - Miss: the lookup issues the refill request after the tag read. Beats are
//    then taken one per cycle while the queue holds them and no result waits
//    in the output register; after the last beat the reads and merge follow,
//    then the emit, or a second tag read and lookup, requesting on a miss.
//  - Rate: one fetch at a time; no item is taken while out_reg holds a result.
//  - Fetches during a refill and beats while idle are dropped, no result.
//  - Reset clears valid bits (flip-flops), the LFSR to one, and the queue.
//  - A stalled out_ready holds the result; the back part waits, the front
//    queue fills and then in_ready falls.
module set_assoc_instruction_cache (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sai_cache_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sai_cache_pkg::out_item_t out_item
);
    import sai_cache_pkg::*;

    logic     q_valid, q_ready;
    in_item_t q_item;

    sai_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sai_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
        .out_item(out_item)
    );
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the set-associative instruction cache.
module tb_top;
    import sai_cache_pkg::*;

    localparam int RUN_ITEMS   = 800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 21;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    set_assoc_instruction_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 2-unit clock period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Cache shadow: tags, valid bits, line bytes, LFSR and the miss state.
    // ------------------------------------------------------------------
    logic [TAG_W-1:0] shadow_tag   [ENTRIES];
    logic             shadow_valid [ENTRIES];
    logic [7:0]       shadow_bytes [ENTRIES*LINE_BYTES];
    logic [15:0]      victim_lfsr;
    logic [31:0]      miss_addr;
    logic [3:0]       miss_len;
    int unsigned      miss_part;   // 0 idle, 1 first part refilling, 2 second part
    logic [63:0]      first_bytes;
    int unsigned      beats_in;
    int unsigned      miss_way;

    out_item_t due_responses[$];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned n_data;
    int unsigned n_refills;
    int unsigned n_dropped;
    int unsigned n_split;
    int unsigned cycles;
    bit          no_idle;

    task automatic shadow_clear();
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
        end
        victim_lfsr = 16'd1;
        miss_addr   = '0;
        miss_len    = '0;
        miss_part   = 0;
        first_bytes = '0;
        beats_in    = 0;
        miss_way    = 0;
    endtask

    function automatic int unsigned set_idx(logic [31:0] a);
        return (a / LINE_BYTES) % SETS;
    endfunction

    function automatic logic [63:0] line_read(logic [31:0] a, int unsigned len,
                                              int unsigned way);
        int unsigned base;
        logic [63:0] v;
        base = (set_idx(a) * WAYS + way) * LINE_BYTES + (a % LINE_BYTES);
        v    = '0;
        for (int i = 0; i < len; i++)
            v |= 64'(shadow_bytes[base + i]) << (8 * i);
        return v;
    endfunction

    // Tag probe; on a miss the victim way is allocated and the refill armed.
    function automatic bit probe_part(logic [31:0] a, int unsigned len,
                                      output logic [63:0] d);
        int unsigned s;
        int unsigned w;
        logic [TAG_W-1:0] t;
        s = set_idx(a);
        t = TAG_W'(a / (LINE_BYTES * SETS));
        d = '0;
        for (w = 0; w < WAYS; w++)
            if (shadow_valid[s*WAYS + w] && shadow_tag[s*WAYS + w] == t)
            begin
                d = line_read(a, len, w);
                return 1'b1;
            end
        for (w = 0; w < WAYS; w++)
            if (!shadow_valid[s*WAYS + w])
                break;
        if (w == WAYS)
        begin
            // all ways in use: advance the Galois LFSR, pick a random victim
            if (victim_lfsr[0])
                victim_lfsr = (victim_lfsr >> 1) ^ LFSR_MASK;
            else
                victim_lfsr = victim_lfsr >> 1;
            w = victim_lfsr % WAYS;
        end
        shadow_valid[s*WAYS + w] = 1'b1;
        shadow_tag[s*WAYS + w]   = t;
        miss_way = w;
        beats_in = 0;
        return 1'b0;
    endfunction

    function automatic int unsigned first_len();
        int unsigned off;
        off = miss_addr % LINE_BYTES;
        return (off + miss_len > LINE_BYTES) ? LINE_BYTES - off : miss_len;
    endfunction

    task automatic push_data(logic [63:0] d);
        out_item_t r;
        r = '0;
        r.result_kind = KIND_DATA;
        r.read_data   = d;
        due_responses.push_back(r);
        n_data++;
    endtask

    task automatic push_refill(logic [31:0] a);
        out_item_t r;
        r = '0;
        r.result_kind    = KIND_REQ;
        r.refill_address = {a[31:OFF_W], {OFF_W{1'b0}}};
        r.refill_way     = 2'(miss_way);
        due_responses.push_back(r);
        n_refills++;
    endtask

    // First part is in first_bytes; look up the second part if any.
    task automatic finish_first();
        int unsigned f;
        int unsigned rest;
        logic [63:0] d2;
        f    = first_len();
        rest = miss_len - f;
        if (rest == 0)
        begin
            miss_part = 0;
            push_data(first_bytes);
        end
        else
        begin
            n_split++;
            if (!probe_part(miss_addr + f, rest, d2))
            begin
                miss_part = 2;
                push_refill(miss_addr + f);
            end
            else
            begin
                miss_part = 0;
                push_data(first_bytes | (d2 << (8 * f)));
            end
        end
    endtask

    // Expected effect of one accepted item.
    task automatic cache_predict(in_item_t it);
        int unsigned len;
        int unsigned base;
        int unsigned f;
        logic [31:0] a;
        logic [63:0] d;
        if (it.action == ACT_FETCH)
        begin
            len = it.fetch_length;
            if (miss_part != 0)
            begin
                n_dropped++;
                return;
            end
            if (len == 0)
            begin
                push_data('0);
                return;
            end
            if (len > 8)
                len = 8;
            miss_addr = it.fetch_address;
            miss_len  = 4'(len);
            if (!probe_part(miss_addr, first_len(), d))
            begin
                miss_part = 1;
                push_refill(miss_addr);
            end
            else
            begin
                first_bytes = d;
                finish_first();
            end
        end
        else
        begin
            if (miss_part == 0)
            begin
                n_dropped++;
                return;
            end
            a = (miss_part == 1) ? miss_addr : miss_addr + first_len();
            base = (set_idx(a) * WAYS + miss_way) * LINE_BYTES + (beats_in % BEATS) * 8;
            for (int i = 0; i < 8; i++)
                shadow_bytes[base + i] = it.refill_data[8*i +: 8];
            beats_in++;
            if (beats_in < BEATS)
                return;
            beats_in = 0;
            if (miss_part == 1)
            begin
                first_bytes = line_read(a, first_len(), miss_way);
                finish_first();
            end
            else
            begin
                f = first_len();
                d = line_read(a, miss_len - f, miss_way);
                miss_part = 0;
                push_data(first_bytes | (d << (8 * f)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(in_item_t it);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        cache_predict(it);
        items_sent++;
    endtask

    task automatic send_fetch(logic [31:0] a, logic [3:0] len);
        in_item_t it;
        it = '0;
        it.action        = ACT_FETCH;
        it.fetch_address = a;
        it.fetch_length  = len;
        it.refill_data   = {$urandom, $urandom};
        send_item(it);
    endtask

    task automatic send_beat(logic [63:0] d);
        in_item_t it;
        it = '0;
        it.action        = ACT_REFILL;
        it.fetch_address = $urandom;
        it.fetch_length  = 4'($urandom);
        it.refill_data   = d;
        send_item(it);
    endtask

    task automatic send_line();
        for (int i = 0; i < BEATS; i++)
            send_beat({$urandom, $urandom});
    endtask

    // Fetch and, if it misses (maybe twice for a split), complete the refills.
    task automatic fetch_filled(logic [31:0] a, logic [3:0] len);
        send_fetch(a, len);
        while (miss_part != 0)
            send_beat({$urandom, $urandom});
    endtask

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result checker: each taken result against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_responses.size() == 0)
                report_mismatch("unexpected result", out_item.read_data, '0);
            else
            begin
                want = due_responses.pop_front();
                if (out_item.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 64'(out_item.result_kind),
                                    64'(want.result_kind));
                if (out_item.read_data !== want.read_data)
                    report_mismatch("read_data", out_item.read_data, want.read_data);
                if (out_item.refill_address !== want.refill_address)
                    report_mismatch("refill_address", 64'(out_item.refill_address),
                                    64'(want.refill_address));
                if (out_item.refill_way !== want.refill_way)
                    report_mismatch("refill_way", 64'(out_item.refill_way),
                                    64'(want.refill_way));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, due_responses.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Cold miss, hit, length extremes, split lines, address wrap, drops.
    task automatic test_directed();
        fetch_filled(32'h0000_0000, 4'd8);
        send_fetch(32'h0000_0003, 4'd1);          // hit, single byte
        send_fetch(32'h0000_0010, 4'd0);          // zero length
        send_fetch(32'h0000_0008, 4'd15);         // clipped to eight
        send_beat(64'hFFFF_FFFF_FFFF_FFFF);       // beat while idle
        send_fetch(32'h0000_103C, 4'd8);          // split, both halves miss
        send_fetch(32'h1234_5678, 4'd4);          // dropped during refill
        while (miss_part != 0)
            send_beat({$urandom, $urandom});
        send_fetch(32'h0000_103D, 4'd7);          // split, both halves hit
        fetch_filled(32'hFFFF_FFFC, 4'd8);        // second half wraps to zero
        fetch_filled(32'hFFFF_FFC0, 4'd8);
    endtask

    // Six tags into one set: forces LFSR victim choice.
    task automatic test_replacement();
        for (int t = 1; t <= 6; t++)
            fetch_filled({20'(t * 7), 6'd5, 6'd0}, 4'd8);
        for (int t = 1; t <= 6; t++)
            fetch_filled({20'(t * 7), 6'd5, 6'd32}, 4'(4 + t));
    endtask

    // Hold off the sender until all outstanding results have drained.
    task automatic test_drain_pause();
        fetch_filled(32'h0000_2040, 4'd8);
        send_fetch(32'h0000_2044, 4'd4);
        in_valid <= 1'b0;
        wait (due_responses.size() == 0);
        @(posedge clk);
        send_fetch(32'h0000_2041, 4'd3);
    endtask

    task automatic test_random(int unsigned count, bit steady);
        int unsigned stop;
        logic [31:0] a;
        no_idle = steady;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            if (miss_part != 0)
            begin
                if ($urandom_range(99) < 90)
                    send_beat({$urandom, $urandom});
                else
                    send_fetch($urandom, 4'($urandom));
            end
            else if ($urandom_range(99) < 6)
                send_beat({$urandom, $urandom});
            else
            begin
                // small tag pool keeps hits and evictions frequent
                if ($urandom_range(99) < 10)
                    a = $urandom;
                else
                    a = {20'($urandom_range(5) * 20'h2A5A5), 6'($urandom_range(7)),
                         6'($urandom)};
                send_fetch(a, 4'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int unsigned left;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        errors     = 0;
        items_sent = 0;
        n_data     = 0;
        n_refills  = 0;
        n_dropped  = 0;
        n_split    = 0;
        no_idle    = 1'b0;
        shadow_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_replacement();
        test_drain_pause();
        left = (items_sent < RUN_ITEMS) ? RUN_ITEMS - items_sent : 0;
        test_random(left / 2, 1'b0);
        test_random(left / 4, 1'b1);          // back-to-back stretch
        test_random((items_sent < RUN_ITEMS) ? RUN_ITEMS - items_sent : 0, 1'b0);

        in_valid <= 1'b0;
        wait (due_responses.size() == 0);
        repeat (60) @(posedge clk);

        $display("Sent %0d items: %0d data results, %0d refill requests,", items_sent,
                 n_data, n_refills);
        $display("%0d line-crossing fetches, %0d items dropped while busy or idle.",
                 n_split, n_dropped);
        if (errors == 0 && due_responses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
